[hdl/ordered_list_append_delete_top_assert.svh]
// assertion macros shared by the list controller and datapath
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ORDERED_LIST_APPEND_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define OLAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define OLAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/olad_pkg.sv]
// shared types and constants for the linked list block
// no dependencies
package olad_pkg;

    // fixed field widths of the channels
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    // free map bits examined per scan cycle
    localparam int CHUNK_W  = 8;

    // command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    issue_head;
        logic    walk_step;
        logic    unlink;
        logic    scan_step;
        logic    alloc;
        logic    link_tail;
        logic    load_res;
        status_t res_code;
    } olad_dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic held_zero;
        logic full;
        logic chunk_hit;
        logic match;
        logic last_node;
    } olad_dp_stat_t;

endpackage

[hdl/olad_cmd_if.sv]
// command channel: one word carries a command bit and a value
// depends on olad_pkg
interface olad_cmd_if;
    import olad_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

[hdl/olad_res_if.sv]
// result channel: one word carries a status code and the entry count
// depends on olad_pkg
interface olad_res_if;
    import olad_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, status, entry_count, input ready);
    modport sink   (input valid, status, entry_count, output ready);
endinterface

[hdl/olad_ctrl.sv]
// controller state machine for the linked list block
// depends on olad_pkg and the assertion macro header
module olad_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  logic                   cmd_command,
    output logic                   cmd_ready,
    input  logic                   res_ready,
    output logic                   res_valid,
    output olad_pkg::olad_dp_cmd_t dp_cmd,
    input  olad_pkg::olad_dp_stat_t dp_stat
);
    import olad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_SCAN,
        S_LINK,
        S_DONE
    } state_t;

    state_t  state_reg;
    status_t code_reg;
    logic    res_valid_reg;
    logic    accept;
    logic    load_res;

    // handshake decode
    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign load_res  = (state_reg == S_DONE) && (!res_valid_reg || res_ready);
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    // state, status code and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd_command == CMD_APPEND)
                        begin
                            if (dp_stat.full)
                            begin
                                code_reg  <= ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_SCAN;
                        end
                        else
                        begin
                            if (dp_stat.held_zero)
                            begin
                                code_reg  <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_HEAD;
                        end
                    end
                end
                S_HEAD:
                    state_reg <= S_WALK;
                S_WALK:
                begin
                    if (dp_stat.match)
                    begin
                        code_reg  <= ST_OK;
                        state_reg <= S_DONE;
                    end
                    else if (dp_stat.last_node)
                    begin
                        code_reg  <= ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (dp_stat.chunk_hit)
                    begin
                        code_reg  <= ST_OK;
                        state_reg <= S_LINK;
                    end
                end
                S_LINK:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (load_res)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath commands
    always_comb
    begin
        dp_cmd            = '0;
        dp_cmd.capture    = accept;
        dp_cmd.issue_head = (state_reg == S_HEAD);
        dp_cmd.walk_step  = (state_reg == S_WALK) && !dp_stat.match && !dp_stat.last_node;
        dp_cmd.unlink     = (state_reg == S_WALK) && dp_stat.match;
        dp_cmd.scan_step  = (state_reg == S_SCAN) && !dp_stat.chunk_hit;
        dp_cmd.alloc      = (state_reg == S_SCAN) && dp_stat.chunk_hit;
        dp_cmd.link_tail  = (state_reg == S_LINK);
        dp_cmd.load_res   = load_res;
        dp_cmd.res_code   = code_reg;
    end

    `include "ordered_list_append_delete_top_assert.svh"

    `OLAD_ASSERT_NEXT(a_one_word_at_a_time, cmd_valid && cmd_ready, !cmd_ready, "word accepted while busy")
    `OLAD_ASSERT_NOW(a_walk_not_empty, state_reg == S_WALK, !dp_stat.held_zero, "walk on empty list")
    `OLAD_ASSERT_NOW(a_scan_not_full, state_reg == S_SCAN, !dp_stat.full, "free scan on full list")

endmodule

[hdl/olad_dpath.sv]
// datapath of the linked list block: slot memories, free map, head, tail, count
// depends on olad_pkg and the assertion macro header
module olad_dpath #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [olad_pkg::VALUE_W-1:0]    value,
    input  olad_pkg::olad_dp_cmd_t                 dp_cmd,
    output olad_pkg::olad_dp_stat_t                dp_stat,
    output olad_pkg::status_t                      res_status,
    output logic [olad_pkg::COUNT_W-1:0]           res_count
);
    import olad_pkg::*;

    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int NCH        = (CAPACITY + CHUNK_W - 1) / CHUNK_W;
    localparam int CIDX_BITS  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PAD_BITS   = NCH * CHUNK_W;
    localparam int OFF_BITS   = $clog2(CHUNK_W);
    localparam int PICK_BITS  = CIDX_BITS + OFF_BITS;
    localparam logic [CIDX_BITS-1:0] LAST_CHUNK = CIDX_BITS'(NCH - 1);

    // slot memories
    logic [VALUE_BITS-1:0] value_mem [CAPACITY];
    logic [SLOT_BITS-1:0]  link_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] value_rd;
    logic [SLOT_BITS-1:0]  link_rd;

    // list control state
    logic [CAPACITY-1:0]   free_reg;
    logic [SLOT_BITS-1:0]  head_reg;
    logic [SLOT_BITS-1:0]  tail_reg;
    logic [CNT_BITS-1:0]   held_reg;

    // per-command working registers
    logic [VALUE_BITS-1:0] val_reg;
    logic [SLOT_BITS-1:0]  node_reg;
    logic [SLOT_BITS-1:0]  prev_reg;
    logic [CNT_BITS-1:0]   idx_reg;
    logic [CIDX_BITS-1:0]  chunk_reg;
    logic [SLOT_BITS-1:0]  pick_reg;
    status_t               res_status_reg;
    logic [COUNT_W-1:0]    res_count_reg;

    logic [VALUE_BITS-1:0] in_val;
    logic [COUNT_W-1:0]    count_word;
    logic [PAD_BITS-1:0]   map_pad;
    logic [CHUNK_W-1:0]    chunk_bits;
    logic [OFF_BITS-1:0]   chunk_off;
    logic [PICK_BITS-1:0]  pick_wide;
    logic [SLOT_BITS-1:0]  pick_slot;
    logic                  held_zero;
    logic                  first_node;
    logic                  last_node;
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic                  link_we;
    logic [SLOT_BITS-1:0]  link_wa;
    logic [SLOT_BITS-1:0]  link_wd;

    // stored value is the low bits of the input word, or the word zero extended
    generate
        if (VALUE_BITS <= VALUE_W)
        begin : g_val_narrow
            assign in_val = value[VALUE_BITS-1:0];
        end
        else
        begin : g_val_wide
            assign in_val = {{(VALUE_BITS - VALUE_W){1'b0}}, value};
        end
    endgenerate

    // entry count modulo the field width
    generate
        if (CNT_BITS >= COUNT_W)
        begin : g_cnt_trunc
            assign count_word = held_reg[COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign count_word = {{(COUNT_W - CNT_BITS){1'b0}}, held_reg};
        end
    endgenerate

    // free map padded to whole chunks, padding reads as taken
    generate
        for (genvar k = 0; k < PAD_BITS; k++)
        begin : g_pad
            if (k < CAPACITY)
            begin : g_real
                assign map_pad[k] = free_reg[k];
            end
            else
            begin : g_fill
                assign map_pad[k] = 1'b0;
            end
        end
    endgenerate

    // lowest free slot within the current chunk
    assign chunk_bits = map_pad[chunk_reg * CHUNK_W +: CHUNK_W];

    always_comb
    begin
        chunk_off = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--)
        begin
            if (chunk_bits[k])
                chunk_off = OFF_BITS'(k);
        end
    end

    assign pick_wide = {chunk_reg, chunk_off};
    assign pick_slot = pick_wide[SLOT_BITS-1:0];

    // walk position decode
    assign held_zero  = (held_reg == '0);
    assign first_node = (idx_reg == '0);
    assign last_node  = ((idx_reg + CNT_BITS'(1)) == held_reg);

    always_comb
    begin
        dp_stat           = '0;
        dp_stat.held_zero = held_zero;
        dp_stat.full      = (held_reg == CNT_BITS'(CAPACITY));
        dp_stat.chunk_hit = |chunk_bits;
        dp_stat.match     = (value_rd == val_reg);
        dp_stat.last_node = last_node;
    end

    // memory read: head first, then follow the link just read
    assign rd_en   = dp_cmd.issue_head || dp_cmd.walk_step;
    assign rd_addr = dp_cmd.walk_step ? link_rd : head_reg;

    // link memory write select
    always_comb
    begin
        link_we = 1'b0;
        link_wa = '0;
        link_wd = '0;
        priority if (dp_cmd.alloc)
        begin
            link_we = 1'b1;
            link_wa = pick_slot;
        end
        else if (dp_cmd.link_tail && !held_zero)
        begin
            link_we = 1'b1;
            link_wa = tail_reg;
            link_wd = pick_reg;
        end
        else if (dp_cmd.unlink && !first_node)
        begin
            link_we = 1'b1;
            link_wa = prev_reg;
            link_wd = last_node ? '0 : link_rd;
        end
    end

    // value memory
    always_ff @(posedge clk)
    begin
        if (dp_cmd.alloc)
            value_mem[pick_slot] <= val_reg;
        if (rd_en)
            value_rd <= value_mem[rd_addr];
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (rd_en)
            link_rd <= link_mem[rd_addr];
    end

    // head, tail, count and free map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= {CAPACITY{1'b1}};
            head_reg <= '0;
            tail_reg <= '0;
            held_reg <= '0;
        end
        else
        begin
            if (dp_cmd.alloc)
                free_reg[pick_slot] <= 1'b0;
            if (dp_cmd.link_tail)
            begin
                if (held_zero)
                    head_reg <= pick_reg;
                tail_reg <= pick_reg;
                held_reg <= held_reg + CNT_BITS'(1);
            end
            if (dp_cmd.unlink)
            begin
                free_reg[node_reg] <= 1'b1;
                held_reg <= held_reg - CNT_BITS'(1);
                if (first_node)
                begin
                    head_reg <= last_node ? '0 : link_rd;
                    if (last_node)
                        tail_reg <= '0;
                end
                else if (last_node)
                    tail_reg <= prev_reg;
            end
        end
    end

    // working registers and result word
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            val_reg   <= in_val;
            node_reg  <= head_reg;
            prev_reg  <= '0;
            idx_reg   <= '0;
            chunk_reg <= '0;
        end
        if (dp_cmd.walk_step)
        begin
            prev_reg <= node_reg;
            node_reg <= link_rd;
            idx_reg  <= idx_reg + CNT_BITS'(1);
        end
        if (dp_cmd.scan_step)
            chunk_reg <= chunk_reg + CIDX_BITS'(1);
        if (dp_cmd.alloc)
            pick_reg <= pick_slot;
        if (dp_cmd.load_res)
        begin
            res_status_reg <= dp_cmd.res_code;
            res_count_reg  <= count_word;
        end
    end

    assign res_status = res_status_reg;
    assign res_count  = res_count_reg;

    `include "ordered_list_append_delete_top_assert.svh"

    // the slot is taken in the cycle before the count moves up on append
    `OLAD_ASSERT_NOW(a_free_matches_count, !dp_cmd.link_tail, $countones(free_reg) == (CAPACITY - int'(held_reg)), "free map disagrees with count")
    `OLAD_ASSERT_NOW(a_scan_in_range, dp_cmd.scan_step, chunk_reg != LAST_CHUNK, "free scan ran past the map")
    `OLAD_ASSERT_NOW(a_single_entry, held_reg == CNT_BITS'(1), head_reg == tail_reg, "single entry with head not tail")

endmodule

[hdl/ordered_list_append_delete_top.sv]
// Bounded singly linked list of up to CAPACITY values.
// Channels: cmd (sink) takes a word holding command (0 append at tail,
// 1 delete first match) and value; res (source) returns one word per command
// holding status (ok, empty, not found, full) and entry_count after it.
// Only the low VALUE_BITS bits of value are stored and compared.
// One command is in work at a time; cmd.ready is high only while idle.
// Append: the free map is scanned 8 slots per cycle until a free slot
// turns up; the slot is taken, linked at the tail and the result loaded.
// Delete: the head is read, then the list is walked with one memory read
// per entry until a match or the last entry; a match is unlinked.
// Delete on an empty list and append on a full one go straight to the result.
// The result word sits in an output register; while res stalls a new
// command is still taken, and its result waits until the register frees.
// Reset (rst_n, asynchronous, active low) empties the list and marks every
// slot free at once; no clearing pass is needed.
// depends on olad_pkg, olad_cmd_if, olad_res_if, olad_ctrl, olad_dpath
module ordered_list_append_delete_top #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    olad_cmd_if.sink  cmd,
    olad_res_if.source res
);
    import olad_pkg::*;

    olad_dp_cmd_t  dp_cmd;
    olad_dp_stat_t dp_stat;

    // controller
    olad_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_command (cmd.command),
        .cmd_ready   (cmd.ready),
        .res_ready   (res.ready),
        .res_valid   (res.valid),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat)
    );

    // datapath
    olad_dpath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (cmd.value),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .res_status (res.status),
        .res_count  (res.entry_count)
    );

endmodule
